// ===== rtl/keyboard_scan_event_queue_assert.svh =====
// Assertion macros for the keyboard scan event queue checker.
// No dependencies; included by the checker file only.
`ifndef KEYBOARD_SCAN_EVENT_QUEUE_ASSERT_SVH
`define KEYBOARD_SCAN_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define KBQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyboard scan event queue: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define KBQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyboard scan event queue: next-cycle check failed");

`endif

// ===== rtl/kbq_pkg.sv =====
// Shared types, constants and helpers for the keyboard scan event queue.
// No dependencies; imported by every module of the block except kbq_ram.
package kbq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ROW_COUNT   = 8;

  localparam int QAW    = $clog2(QUEUE_DEPTH);
  localparam int QFW    = $clog2(QUEUE_DEPTH + 1);
  localparam int QSW    = QFW + 1;
  localparam int ROW_AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  localparam logic [6:0] POWER_KEY    = 7'h5d;
  localparam logic [6:0] GUARDED_KEY  = 7'h6f;
  localparam int         POWER_COL    = 13;
  localparam logic [2:0] POWER_ROW    = 3'd5;
  localparam logic [7:0] POWER_DOWN   = 8'h7f;
  localparam logic [7:0] POWER_UP     = 8'hff;
  localparam logic [7:0] RELEASE_FLAG = 8'h80;
  localparam logic [7:0] FILL_BYTE    = 8'hff;
  localparam logic [7:0] MOD_RESET    = 8'hff;

  localparam logic [6:0] KEY_CAPS    = 7'h39;
  localparam logic [6:0] KEY_CONTROL = 7'h36;
  localparam logic [6:0] KEY_SHIFT   = 7'h38;
  localparam logic [6:0] KEY_OPTION  = 7'h3a;
  localparam logic [6:0] KEY_COMMAND = 7'h37;

  localparam logic [1:0] TALK_REG_KEYS = 2'd0;
  localparam logic [1:0] TALK_REG_MODS = 2'd2;
  localparam logic [1:0] REPLY_NONE    = 2'd0;
  localparam logic [1:0] REPLY_TWO     = 2'd2;

  typedef enum logic [1:0] {
    REQ_SCAN,
    REQ_TALK,
    REQ_COMPLETE,
    REQ_RESET
  } kbq_req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_SCAN,
    ST_TALK_A,
    ST_TALK_B,
    ST_EMIT
  } kbq_state_t;

  typedef struct packed {
    kbq_req_kind_t req_type;
    logic [2:0]    row_index;
    logic [15:0]   row_bits;
    logic [1:0]    talk_register;
    logic          talk_ok;
  } kbq_request_t;

  typedef struct packed {
    logic [1:0] reply_length;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       service_request;
    logic       keys_down;
    logic       power_line_active;
  } kbq_response_t;

  // Control from the sequencer to the code queue
  typedef struct packed {
    logic       clear;
    logic       push;
    logic [7:0] code;
    logic       rd_first;
    logic       rd_second;
    logic       arm;
    logic       drop;
    logic       pop;
  } kbq_qctl_t;

  // Status back from the code queue
  typedef struct packed {
    logic       not_empty;
    logic       more_than_one;
    logic [7:0] rd_data;
  } kbq_qstat_t;

  // Active-low modifier bit touched by a key, zero for ordinary keys
  function automatic logic [7:0] modifier_mask(input logic [6:0] key);
    logic [7:0] m;
    unique case (key)
      KEY_CAPS:    m = 8'h20;
      KEY_CONTROL: m = 8'h08;
      KEY_SHIFT:   m = 8'h04;
      KEY_OPTION:  m = 8'h02;
      KEY_COMMAND: m = 8'h01;
      default:     m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/kbq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kbq_queue.sv =====
// Code ring: ring RAM plus head, fill count and pending pop count.
// Depends on kbq_pkg and kbq_ram.
module kbq_queue (
  input  logic               clk,
  input  logic               rst,
  input  kbq_pkg::kbq_qctl_t ctl,
  output kbq_pkg::kbq_qstat_t stat
);
  import kbq_pkg::*;

  logic [QAW-1:0] head;
  logic [QFW-1:0] fill;
  logic [1:0]     pending;

  logic [QSW-1:0] wr_sum;
  logic [QAW-1:0] wr_idx;
  logic [QAW-1:0] head_inc;
  logic [QAW-1:0] rd_idx;
  logic           full;
  logic           wr_en;
  logic [1:0]     pop_n;
  logic [QSW-1:0] pop_sum;
  logic [QAW-1:0] head_pop;

  // tail slot = (head + fill) mod depth, sum stays below twice the depth
  always_comb begin
    wr_sum   = QSW'(head) + QSW'(fill);
    wr_idx   = (wr_sum >= QSW'(QUEUE_DEPTH)) ? QAW'(wr_sum - QSW'(QUEUE_DEPTH))
                                             : QAW'(wr_sum);
    head_inc = (head == QAW'(QUEUE_DEPTH - 1)) ? '0 : head + QAW'(1);
    rd_idx   = ctl.rd_second ? head_inc : head;
    full     = (fill == QFW'(QUEUE_DEPTH));
    wr_en    = ctl.push && !full;
    pop_n    = (QFW'(pending) > fill) ? fill[1:0] : pending;
    pop_sum  = QSW'(head) + QSW'(pop_n);
    head_pop = (pop_sum >= QSW'(QUEUE_DEPTH)) ? QAW'(pop_sum - QSW'(QUEUE_DEPTH))
                                              : QAW'(pop_sum);
  end

  kbq_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (ctl.code),
    .raddr (rd_idx),
    .rdata (stat.rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head    <= '0;
      fill    <= '0;
      pending <= '0;
    end else begin
      if (ctl.pop) begin
        head <= head_pop;
        fill <= fill - QFW'(pop_n);
      end else if (wr_en) begin
        fill <= fill + QFW'(1);
      end
      if (ctl.arm) begin
        pending <= (fill == '0) ? 2'd0 : ((fill > QFW'(1)) ? 2'd2 : 2'd1);
      end else if (ctl.drop) begin
        pending <= '0;
      end
    end
  end

  assign stat.not_empty     = (fill != '0);
  assign stat.more_than_one = (fill > QFW'(1));

endmodule

// ===== rtl/keyboard_scan_event_queue.sv =====
// Top level of the keyboard scan event queue: request sequencer, key matrix
// RAM and modifier/power bookkeeping. Depends on kbq_pkg, kbq_ram, kbq_queue.
//
//  channel   | ports                       | handshake
//  ----------+-----------------------------+-----------------------------------
//  request   | start, busy, request        | taken when start && !busy
//  response  | done, response              | one-cycle strobe, no back-pressure
//
// A scan of an in-range row walks all 16 columns, one per cycle, so that each queued
// code gets its own ring write; a changing power key holds its column for a second write.
// Reset (rst, synchronous) clears control state; the ring needs no clearing
// because only entries below the fill count are ever used.
// busy stays high from acceptance until the cycle after done.
module keyboard_scan_event_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  kbq_pkg::kbq_request_t  request,
  output logic                   busy,
  output logic                   done,
  output kbq_pkg::kbq_response_t response
);
  import kbq_pkg::*;

  kbq_state_t state, state_next;
  kbq_request_t req;

  // scan bookkeeping
  logic [15:0]          changes;
  logic [3:0]           col;
  logic                 second;          // power key: second copy still due
  logic                 power_changing;
  logic                 down_acc;
  logic                 down_flag;
  logic                 power_line;
  logic [7:0]           modifier;
  logic [ROW_COUNT-1:0] mat_valid;       // rows written since reset

  // reply held for the done cycle
  logic [1:0] reply_len;
  logic [7:0] reply_b0;
  logic [7:0] reply_b1;

  // key matrix RAM
  logic              mat_we;
  logic [ROW_AW-1:0] mat_addr;
  logic [15:0]       mat_rdata;
  logic [15:0]       old_bits;
  logic [15:0]       diff_bits;
  logic              acc_new;

  kbq_qctl_t  qctl;
  kbq_qstat_t qstat;

  // column walk
  logic       row_in_range;
  logic       last_row;
  logic [6:0] col_key;
  logic       col_changed;
  logic       col_pressed;
  logic       is_power;
  logic       guarded;
  logic       stay;
  logic       scan_last;

  assign mat_addr     = req.row_index[ROW_AW-1:0];
  assign row_in_range = ({1'b0, req.row_index} < 4'(ROW_COUNT));
  assign last_row     = ({1'b0, req.row_index} == 4'(ROW_COUNT - 1));

  // an unwritten row reads as all keys up
  assign old_bits  = mat_valid[mat_addr] ? mat_rdata : '0;
  assign diff_bits = req.row_bits ^ old_bits;
  assign acc_new   = ((req.row_index == 3'd0) ? 1'b0 : down_acc) | (req.row_bits != '0);

  assign col_key     = {req.row_index, col};
  assign col_changed = changes[col];
  assign col_pressed = req.row_bits[col];
  assign is_power    = (col_key == POWER_KEY);
  assign guarded     = (col_key == GUARDED_KEY) && power_changing;
  assign stay        = col_changed && is_power && !second;
  assign scan_last   = (col == 4'hf) && !stay;

  kbq_ram #(.WIDTH(16), .DEPTH(ROW_COUNT)) u_matrix (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_addr),
    .wdata (req.row_bits),
    .raddr (mat_addr),
    .rdata (mat_rdata)
  );

  kbq_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl),
    .stat (qstat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (req.req_type)
          REQ_SCAN: state_next = row_in_range ? ST_LOAD : ST_EMIT;
          REQ_TALK: begin
            state_next = (req.talk_register == TALK_REG_KEYS && qstat.not_empty)
                         ? ST_TALK_A : ST_EMIT;
          end
          REQ_COMPLETE: state_next = ST_EMIT;
          REQ_RESET:    state_next = ST_EMIT;
        endcase
      end
      ST_LOAD:   state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_EMIT;
      ST_TALK_A: state_next = ST_TALK_B;
      ST_TALK_B: state_next = ST_EMIT;
      ST_EMIT:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy   = (state != ST_IDLE);
    done   = (state == ST_EMIT);
    mat_we = (state == ST_SCAN) && scan_last;
    qctl   = '0;
    qctl.code = is_power ? (col_pressed ? POWER_DOWN : POWER_UP)
                         : ({1'b0, col_key} | (col_pressed ? 8'h00 : RELEASE_FLAG));
    unique case (state)
      ST_EXEC: begin
        unique case (req.req_type)
          REQ_SCAN: ;
          REQ_TALK: begin
            qctl.arm      = (req.talk_register == TALK_REG_KEYS);
            qctl.drop     = 1'b1;
            qctl.rd_first = 1'b1;
          end
          REQ_COMPLETE: begin
            qctl.pop  = (req.talk_register == TALK_REG_KEYS) && req.talk_ok;
            qctl.drop = 1'b1;
          end
          REQ_RESET: qctl.clear = 1'b1;
        endcase
      end
      ST_SCAN:   qctl.push = col_changed && (is_power || !guarded);
      ST_TALK_A: qctl.rd_second = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      col            <= '0;
      second         <= 1'b0;
      power_changing <= 1'b0;
      down_acc       <= 1'b0;
      down_flag      <= 1'b0;
      power_line     <= 1'b1;
      modifier       <= MOD_RESET;
      mat_valid      <= '0;
      reply_len      <= REPLY_NONE;
      reply_b0       <= '0;
      reply_b1       <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (start) req <= request;
        ST_EXEC: begin
          col       <= '0;
          second    <= 1'b0;
          if (req.req_type == REQ_TALK && req.talk_register == TALK_REG_MODS) begin
            reply_len <= REPLY_TWO;
            reply_b0  <= modifier;
            reply_b1  <= FILL_BYTE;
          end else begin
            reply_len <= REPLY_NONE;
            reply_b0  <= '0;
            reply_b1  <= '0;
          end
          if (req.req_type == REQ_RESET) begin
            mat_valid      <= '0;
            modifier       <= MOD_RESET;
            power_changing <= 1'b0;
            down_acc       <= 1'b0;
            down_flag      <= 1'b0;
            power_line     <= ~req.row_bits[POWER_COL];
          end
        end
        ST_LOAD: begin
          changes  <= diff_bits;
          down_acc <= acc_new;
          if (req.row_index == POWER_ROW) power_changing <= diff_bits[POWER_COL];
          if (last_row) down_flag <= acc_new;
        end
        ST_SCAN: begin
          if (col_changed && !second) begin
            modifier <= col_pressed ? (modifier & ~modifier_mask(col_key))
                                    : (modifier | modifier_mask(col_key));
          end
          if (col_changed && is_power) power_line <= ~col_pressed;
          if (stay) begin
            second <= 1'b1;
          end else begin
            second <= 1'b0;
            col    <= col + 4'd1;
          end
          if (scan_last) mat_valid[mat_addr] <= 1'b1;
        end
        ST_TALK_A: reply_b1 <= qstat.rd_data;
        ST_TALK_B: begin
          reply_b0  <= qstat.more_than_one ? qstat.rd_data : FILL_BYTE;
          reply_len <= REPLY_TWO;
        end
        ST_EMIT: ;
        default: ;
      endcase
    end
  end

  assign response.reply_length      = reply_len;
  assign response.first_byte        = reply_b0;
  assign response.second_byte       = reply_b1;
  assign response.service_request   = qstat.not_empty;
  assign response.keys_down         = down_flag;
  assign response.power_line_active = power_line;

endmodule

// ===== rtl/kbq_checker.sv =====
// Port-level checker for the keyboard scan event queue, bound to the top level.
// Depends on kbq_pkg and keyboard_scan_event_queue_assert.svh.
`include "keyboard_scan_event_queue_assert.svh"

module kbq_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input kbq_pkg::kbq_response_t response
);
  import kbq_pkg::*;

  logic len_legal;
  logic len_none;
  logic bytes_zero;

  assign len_legal  = (response.reply_length == REPLY_NONE) ||
                      (response.reply_length == REPLY_TWO);
  assign len_none   = (response.reply_length == REPLY_NONE);
  assign bytes_zero = (response.first_byte == 8'h00) && (response.second_byte == 8'h00);

  `KBQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `KBQ_ASSERT_NOW(a_done_busy, done, busy)
  `KBQ_ASSERT_NEXT(a_done_single, done, !done && !busy)
  `KBQ_ASSERT_NOW(a_len_legal, done, len_legal)
  `KBQ_ASSERT_NOW(a_empty_reply, done && len_none, bytes_zero)

endmodule

bind keyboard_scan_event_queue kbq_checker u_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for keyboard_scan_event_queue: directed and random requests
// (scans, talks, completions and bus resets) checked against an in-bench predictor.
// Depends on kbq_pkg and the block's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kbq_pkg::*;

  localparam int STALL_LIMIT   = 2000; // cycles with no request taken and no reply
  localparam int RANDOM_ITEMS  = 1950;
  localparam int SETTLE_CYCLES = 40;   // well over the slowest request
  localparam int DRAIN_EVERY   = 300;

  // Talk registers the keyboard does not answer
  localparam logic [1:0] TALK_REG_SPARE_A = 2'd1;
  localparam logic [1:0] TALK_REG_SPARE_B = 2'd3;

  // Predicts every reply from the requests taken, and holds the replies still owed.
  class kbq_reply_tracker;
    logic [15:0]   matrix [ROW_COUNT];
    logic [7:0]    ring [QUEUE_DEPTH];
    int            head;
    int            fill;
    int            pending_pops;
    logic [7:0]    modifiers;
    bit            power_changing;
    bit            down_acc;
    bit            down_flag;
    bit            power_line;
    kbq_response_t owed_replies [$];
    int            errors;

    function new();
      clear_all();
      power_line = 1'b1;
      errors     = 0;
    endfunction

    function void clear_all();
      foreach (matrix[i]) matrix[i] = '0;
      foreach (ring[i]) ring[i] = '0;
      head           = 0;
      fill           = 0;
      pending_pops   = 0;
      modifiers      = MOD_RESET;
      power_changing = 1'b0;
      down_acc       = 1'b0;
      down_flag      = 1'b0;
    endfunction

    function void push_code(logic [7:0] code);
      if (fill >= QUEUE_DEPTH) return;
      ring[(head + fill) % QUEUE_DEPTH] = code;
      fill++;
    endfunction

    function void scan_row(int row, logic [15:0] bits);
      logic [15:0] changes;
      logic [6:0]  key;
      logic [7:0]  mod_bit;
      bit          pressed;
      changes = bits ^ matrix[row];
      if (row == 0) down_acc = 1'b0;
      if (row == POWER_ROW) power_changing = changes[POWER_COL];
      if (bits != '0) down_acc = 1'b1;
      for (int col = 0; col < 16; col++) begin
        if (changes[col]) begin
          pressed = bits[col];
          key     = 7'(row * 16 + col);
          case (key)
            KEY_CAPS:    mod_bit = 8'h20;
            KEY_CONTROL: mod_bit = 8'h08;
            KEY_SHIFT:   mod_bit = 8'h04;
            KEY_OPTION:  mod_bit = 8'h02;
            KEY_COMMAND: mod_bit = 8'h01;
            default:     mod_bit = 8'h00;
          endcase
          // active low: press clears, release sets
          modifiers = pressed ? (modifiers & ~mod_bit) : (modifiers | mod_bit);
          if (key == POWER_KEY) begin
            power_line = !pressed;
            push_code(pressed ? POWER_DOWN : POWER_UP);
            push_code(pressed ? POWER_DOWN : POWER_UP);
          end else if (key != GUARDED_KEY || !power_changing) begin
            push_code({1'b0, key} | (pressed ? 8'h00 : RELEASE_FLAG));
          end
        end
      end
      matrix[row] = bits;
      if (row == ROW_COUNT - 1) down_flag = down_acc;
    endfunction

    function void apply_request(kbq_request_t req);
      kbq_response_t r;
      int            n;
      r = '0;
      case (req.req_type)
        REQ_SCAN: begin
          if (req.row_index < ROW_COUNT) scan_row(req.row_index, req.row_bits);
        end
        REQ_TALK: begin
          pending_pops = 0;
          if (req.talk_register == TALK_REG_KEYS) begin
            if (fill != 0) begin
              r.second_byte = ring[head];
              pending_pops  = 1;
              if (fill > 1) begin
                r.first_byte = ring[(head + 1) % QUEUE_DEPTH];
                pending_pops = 2;
              end else begin
                r.first_byte = FILL_BYTE;
              end
              r.reply_length = REPLY_TWO;
            end
          end else if (req.talk_register == TALK_REG_MODS) begin
            r.first_byte   = modifiers;
            r.second_byte  = FILL_BYTE;
            r.reply_length = REPLY_TWO;
          end
        end
        REQ_COMPLETE: begin
          if (req.talk_register == TALK_REG_KEYS && req.talk_ok) begin
            n    = (pending_pops > fill) ? fill : pending_pops;
            head = (head + n) % QUEUE_DEPTH;
            fill -= n;
          end
          pending_pops = 0;
        end
        default: begin
          clear_all();
          power_line = !req.row_bits[POWER_COL];
        end
      endcase
      r.service_request   = (fill != 0);
      r.keys_down         = down_flag;
      r.power_line_active = power_line;
      owed_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(kbq_response_t got);
      kbq_response_t want;
      if (owed_replies.size() == 0) begin
        $error("reply with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      compare_field("reply_length", want.reply_length, got.reply_length);
      compare_field("first_byte", want.first_byte, got.first_byte);
      compare_field("second_byte", want.second_byte, got.second_byte);
      compare_field("service_request", want.service_request, got.service_request);
      compare_field("keys_down", want.keys_down, got.keys_down);
      compare_field("power_line_active", want.power_line_active, got.power_line_active);
    endfunction

    function int outstanding();
      return owed_replies.size();
    endfunction
  endclass

  logic          clk;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  kbq_request_t  request = '0;
  logic          busy;
  logic          done;
  kbq_response_t response;

  kbq_reply_tracker tracker = new();

  // What the bench believes the matrix holds, so that sweeps mostly toggle only a few keys
  logic [15:0] held_keys [ROW_COUNT];
  int          items_sent = 0;
  int          stall_cycles = 0;
  bit          steady_phase = 1'b0; // no sender gaps while set

  keyboard_scan_event_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Everything is sampled on the rising edge: replies are checked before the
  // request taken at the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done === 1'b1) tracker.check_reply(response);
      if (start && busy === 1'b0) tracker.apply_request(request);
      stall_cycles <= (done === 1'b1 || (start && busy === 1'b0)) ? 0 : stall_cycles + 1;
    end
  end

  // Hang guard: nothing taken and nothing returned for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Random content everywhere; callers overwrite the fields that matter
  function automatic kbq_request_t noise_request();
    kbq_request_t r;
    r.req_type      = kbq_req_kind_t'($urandom_range(0, 3));
    r.row_index     = 3'($urandom_range(0, 7));
    r.row_bits      = 16'($urandom_range(0, 65535));
    r.talk_register = 2'($urandom_range(0, 3));
    r.talk_ok       = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken, later if a sender gap follows.
  task automatic send_request(input kbq_request_t req);
    request = req;
    start   = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
    if (req.req_type == REQ_SCAN) held_keys[req.row_index] = req.row_bits;
    if (req.req_type == REQ_RESET) foreach (held_keys[i]) held_keys[i] = '0;
    items_sent++;
    if (!steady_phase && $urandom_range(0, 99) < 9) begin
      start = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  task automatic scan(input int row, input logic [15:0] bits);
    kbq_request_t r;
    r           = noise_request();
    r.req_type  = REQ_SCAN;
    r.row_index = 3'(row);
    r.row_bits  = bits;
    send_request(r);
  endtask

  task automatic talk(input logic [1:0] bus_reg);
    kbq_request_t r;
    r               = noise_request();
    r.req_type      = REQ_TALK;
    r.talk_register = bus_reg;
    send_request(r);
  endtask

  task automatic complete(input logic [1:0] bus_reg, input bit ok);
    kbq_request_t r;
    r               = noise_request();
    r.req_type      = REQ_COMPLETE;
    r.talk_register = bus_reg;
    r.talk_ok       = ok;
    send_request(r);
  endtask

  task automatic bus_reset(input logic [15:0] row5_bits);
    kbq_request_t r;
    r          = noise_request();
    r.req_type = REQ_RESET;
    r.row_bits = row5_bits;
    send_request(r);
  endtask

  // Sender holds off until every owed reply is back
  task automatic wait_drained();
    start = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One full matrix scan, rows in order, mostly small changes from the held state.
  // Power key, the guarded key and the modifiers get toggled more often.
  task automatic scan_sweep();
    logic [15:0] bits;
    int          pick;
    for (int row = 0; row < ROW_COUNT; row++) begin
      bits = held_keys[row];
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        bits = 16'($urandom_range(0, 65535));
      end else if (pick < 6) begin
        bits = '0;
      end else if (pick < 7) begin
        bits = '1;
      end else begin
        repeat ($urandom_range(0, 2)) bits[$urandom_range(0, 15)] ^= 1'b1;
        if (row == POWER_ROW && $urandom_range(0, 99) < 15) bits[POWER_COL] ^= 1'b1;
        if (row == GUARDED_KEY[6:4] && $urandom_range(0, 99) < 15)
          bits[GUARDED_KEY[3:0]] ^= 1'b1;
        if (row == KEY_CAPS[6:4] && $urandom_range(0, 99) < 25)
          bits[$urandom_range(KEY_CONTROL[3:0], KEY_OPTION[3:0])] ^= 1'b1;
      end
      scan(row, bits);
    end
  endtask

  // Host polling: talk then (usually) a matching completion
  task automatic talk_exchange();
    logic [1:0] bus_reg;
    repeat ($urandom_range(1, 4)) begin
      bus_reg = ($urandom_range(0, 99) < 80) ? TALK_REG_KEYS : 2'($urandom_range(0, 3));
      talk(bus_reg);
      if ($urandom_range(0, 99) < 90)
        complete(($urandom_range(0, 99) < 85) ? bus_reg : 2'($urandom_range(0, 3)),
                 $urandom_range(0, 99) < 85);
    end
  endtask

  initial begin
    int target;
    int next_drain;
    int steady_from;
    int pick;

    foreach (held_keys[i]) held_keys[i] = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // --- directed part ---
    talk(TALK_REG_KEYS);          // empty ring: no reply bytes
    talk(TALK_REG_MODS);          // modifiers at reset
    talk(TALK_REG_SPARE_A);
    talk(TALK_REG_SPARE_B);
    scan(0, 16'hffff);            // 16 presses
    scan(1, 16'hffff);            // ring now full
    scan(2, 16'h0001);            // dropped
    scan(3, 16'h07c0);            // all five modifiers down, codes dropped
    talk(TALK_REG_MODS);
    talk(TALK_REG_KEYS);
    complete(TALK_REG_KEYS, 1'b0); // failed completion keeps the codes
    talk(TALK_REG_KEYS);
    complete(TALK_REG_MODS, 1'b1); // wrong register keeps the codes
    talk(TALK_REG_KEYS);
    complete(TALK_REG_KEYS, 1'b1); // pops two
    complete(TALK_REG_KEYS, 1'b1); // nothing pending any more
    bus_reset(16'h2000);          // power key held through the reset
    scan(POWER_ROW, 16'h2000);    // power press: two power codes, line stays low
    scan(6, 16'h8000);            // guarded key while power is changing: not queued
    scan(7, 16'h0000);
    talk(TALK_REG_KEYS);
    complete(TALK_REG_KEYS, 1'b1);
    scan(POWER_ROW, 16'h0000);    // power release
    scan(POWER_ROW, 16'h0000);    // no change, guard lifted
    scan(6, 16'h0000);            // guarded key release now queued
    wait_drained();

    // --- random part ---
    target      = items_sent + RANDOM_ITEMS;
    next_drain  = items_sent + DRAIN_EVERY;
    steady_from = items_sent + $urandom_range(500, 800);
    while (items_sent < target) begin
      steady_phase = (items_sent >= steady_from) && (items_sent < steady_from + 400);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        scan_sweep();
      end else if (pick < 80) begin
        talk_exchange();
      end else if (pick < 85) begin
        // broken exchanges: lone talk or lone completion
        if ($urandom_range(0, 1)) talk(2'($urandom_range(0, 3)));
        else complete(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        bus_reset(($urandom_range(0, 1) != 0) ? held_keys[POWER_ROW]
                                               : 16'($urandom_range(0, 65535)));
      end else begin
        send_request(noise_request());
      end
      // no drain pauses inside the gap-free stretch
      if (items_sent >= next_drain && !steady_phase) begin
        wait_drained();
        next_drain = items_sent + DRAIN_EVERY;
      end
    end
    steady_phase = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0)
      $error("%0d replies never arrived", tracker.outstanding());
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kbq_pkg.sv
rtl/kbq_ram.sv
rtl/kbq_queue.sv
rtl/keyboard_scan_event_queue.sv
rtl/kbq_checker.sv
verif/testbench.sv
